### hw/rtl/hdbrp_pkg.sv
// Package for the hash-database record parser.
// Holds the phase and role codes, register indexes, the result beat type
// and the helper that picks the first non-empty body section of a record.
package hdbrp_pkg;

  localparam logic [7:0] MagicData = 8'hc8;
  localparam logic [7:0] MagicFree = 8'hb0;

  // Header bytes after the magic: hash byte plus two links.
  localparam logic [31:0] HdrLenNarrow = 32'd9;
  localparam logic [31:0] HdrLenWide   = 32'd17;
  localparam logic [31:0] FreeLen      = 32'd4;

  localparam int unsigned PosW    = 48;
  localparam int unsigned LenW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 48;

  // Reset value of the alignment exponent.
  localparam logic [3:0] AlignPowReset = 4'd4;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_OFFSET  = 2'd0,
    CFG_ALIGNMENT_POW = 2'd1,
    CFG_WIDE_LINKS    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_SCAN    = 4'd0,
    PH_HDR     = 4'd1,
    PH_PAD0    = 4'd2,
    PH_PAD1    = 4'd3,
    PH_KEYVAR  = 4'd4,
    PH_VALVAR  = 4'd5,
    PH_KEY     = 4'd6,
    PH_VAL     = 4'd7,
    PH_PADDING = 4'd8,
    PH_FREE    = 4'd9,
    PH_ALIGN   = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_HDR   = 2'd0,
    ROLE_KEY   = 2'd1,
    ROLE_VALUE = 2'd2
  } role_e;

  // One result beat.
  typedef struct packed {
    logic [7:0]      byte_value;
    role_e           byte_role;
    logic            record_done;
    logic [PosW-1:0] record_base;
    logic [LenW-1:0] key_length;
    logic [LenW-1:0] value_length;
  } result_t;

  // Restart request from the configuration side.
  typedef struct packed {
    logic            load;
    logic [PosW-1:0] offset;
  } restart_t;

  // Outcome of entering the record body.
  typedef struct packed {
    phase_e          phase;
    logic [LenW-1:0] remaining;
    logic            done;
  } body_t;

  // Enter the first non-empty section from the given one onward.
  function automatic body_t enter_body(phase_e from, logic [LenW-1:0] klen,
                                       logic [LenW-1:0] vlen,
                                       logic [15:0] plen);
    body_t r;
    r.phase     = PH_SCAN;
    r.remaining = '0;
    r.done      = 1'b1;
    if (from == PH_KEY && klen != '0) begin
      r.phase     = PH_KEY;
      r.remaining = klen;
      r.done      = 1'b0;
    end else if (from != PH_PADDING && vlen != '0) begin
      r.phase     = PH_VAL;
      r.remaining = vlen;
      r.done      = 1'b0;
    end else if (plen != '0) begin
      r.phase     = PH_PADDING;
      r.remaining = {16'd0, plen};
      r.done      = 1'b0;
    end
    return r;
  endfunction

endpackage

### hw/rtl/hdbrp_parser.sv
// Record parser state machine: one byte per beat, one result per byte.
// Depends on hdbrp_pkg for phase codes, result type and enter_body.
module hdbrp_parser import hdbrp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  restart_t           restart_i,
  input  logic [3:0]         align_pow_i,
  input  logic               wide_links_i,
  output result_t            result_o
);

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] remaining_q, remaining_d;
  logic [LenW-1:0] vsum_q, vsum_d;
  logic [5:0]      vshift_q, vshift_d;
  logic [15:0]     pad_q, pad_d;
  logic [LenW-1:0] key_q, key_d;
  logic [LenW-1:0] val_q, val_d;
  logic [PosW-1:0] rstart_q, rstart_d;

  logic [PosW-1:0] next_pos;
  logic [15:0]     amask;
  logic            aligned;
  logic [6:0]      term;
  logic [LenW-1:0] vsum_add;
  logic [LenW-1:0] rem_dec;
  logic            done;
  role_e           role;
  body_t           body;

  // Next state for one byte.
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    vsum_d      = vsum_q;
    vshift_d    = vshift_q;
    pad_d       = pad_q;
    key_d       = key_q;
    val_d       = val_q;
    rstart_d    = rstart_q;
    done        = 1'b0;
    role        = ROLE_HDR;
    body        = '{phase: PH_SCAN, remaining: '0, done: 1'b0};

    next_pos = pos_q + PosW'(1);
    amask    = ~(16'hffff << align_pow_i);
    aligned  = (next_pos[15:0] & amask) == 16'd0;
    rem_dec  = remaining_q - LenW'(1);

    // Varint term; the shift saturates at 35, so bit 5 means no more terms.
    term     = data_byte_i[7] ? ~data_byte_i[6:0] : data_byte_i[6:0];
    vsum_add = vshift_q[5] ? vsum_q : vsum_q + (LenW'(term) << vshift_q[4:0]);

    unique case (phase_q)
      PH_SCAN: begin
        rstart_d = pos_q;
        if (data_byte_i == MagicData) begin
          phase_d     = PH_HDR;
          remaining_d = wide_links_i ? HdrLenWide : HdrLenNarrow;
          key_d       = '0;
          val_d       = '0;
          pad_d       = '0;
        end else if (data_byte_i == MagicFree) begin
          phase_d     = PH_FREE;
          remaining_d = FreeLen;
        end else if (!aligned) begin
          phase_d = PH_ALIGN;
        end
      end
      PH_HDR: begin
        remaining_d = rem_dec;
        if (rem_dec == '0) phase_d = PH_PAD0;
      end
      PH_PAD0: begin
        pad_d   = {8'd0, data_byte_i};
        phase_d = PH_PAD1;
      end
      PH_PAD1: begin
        pad_d    = {data_byte_i, pad_q[7:0]};
        vsum_d   = '0;
        vshift_d = '0;
        phase_d  = PH_KEYVAR;
      end
      PH_KEYVAR, PH_VALVAR: begin
        vsum_d = vsum_add;
        if (data_byte_i[7]) begin
          vshift_d = (vshift_q > 6'd28) ? 6'd35 : vshift_q + 6'd7;
        end else if (phase_q == PH_KEYVAR) begin
          key_d    = vsum_add;
          vsum_d   = '0;
          vshift_d = '0;
          phase_d  = PH_VALVAR;
        end else begin
          val_d       = vsum_add;
          vsum_d      = '0;
          vshift_d    = '0;
          body        = enter_body(PH_KEY, key_q, vsum_add, pad_q);
          phase_d     = body.phase;
          remaining_d = body.remaining;
          done        = body.done;
        end
      end
      PH_KEY: begin
        role        = ROLE_KEY;
        remaining_d = rem_dec;
        if (rem_dec == '0) begin
          body        = enter_body(PH_VAL, key_q, val_q, pad_q);
          phase_d     = body.phase;
          remaining_d = body.remaining;
          done        = body.done;
        end
      end
      PH_VAL: begin
        role        = ROLE_VALUE;
        remaining_d = rem_dec;
        if (rem_dec == '0) begin
          body        = enter_body(PH_PADDING, key_q, val_q, pad_q);
          phase_d     = body.phase;
          remaining_d = body.remaining;
          done        = body.done;
        end
      end
      PH_PADDING: begin
        remaining_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = PH_SCAN;
          done    = 1'b1;
        end
      end
      PH_FREE: begin
        remaining_d = rem_dec;
        if (rem_dec == '0) phase_d = PH_SCAN;
      end
      PH_ALIGN: begin
        if (aligned) phase_d = PH_SCAN;
      end
      default: begin
        phase_d = PH_SCAN;
      end
    endcase

    pos_d = next_pos;
  end

  // Result beat for the current byte.
  always_comb begin
    result_o.byte_value   = data_byte_i;
    result_o.byte_role    = role;
    result_o.record_done  = done;
    result_o.record_base  = rstart_d;
    result_o.key_length   = key_d;
    result_o.value_length = val_d;
  end

  // State registers; a start-offset write restarts the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SCAN;
      pos_q       <= '0;
      remaining_q <= '0;
      vsum_q      <= '0;
      vshift_q    <= '0;
      pad_q       <= '0;
      key_q       <= '0;
      val_q       <= '0;
      rstart_q    <= '0;
    end else if (restart_i.load) begin
      phase_q     <= PH_SCAN;
      pos_q       <= restart_i.offset;
      remaining_q <= '0;
      vsum_q      <= '0;
      vshift_q    <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      remaining_q <= remaining_d;
      vsum_q      <= vsum_d;
      vshift_q    <= vshift_d;
      pad_q       <= pad_d;
      key_q       <= key_d;
      val_q       <= val_d;
      rstart_q    <= rstart_d;
    end
  end

  // A finished record always returns the parser to scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.record_done |=> phase_q == PH_SCAN)
    else $error("parser left scan state after record end");

  // Key and value bytes only come out of the body phases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.byte_role != ROLE_HDR |-> phase_q == PH_KEY || phase_q == PH_VAL)
    else $error("body role outside body phase");

  // Each byte without a restart advances the file position by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !restart_i.load |=> pos_q == $past(pos_q) + PosW'(1))
    else $error("position did not advance");

endmodule

### hw/rtl/hdbrp_out_buf.sv
// Two-entry result buffer: an output register plus a skid entry.
// Depends on hdbrp_pkg for the result beat type.
module hdbrp_out_buf import hdbrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = main_valid_q && !out_stall_i;

  // Refill the output register from the skid entry first to keep order.
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_d       = push_data_i;
        skid_valid_d = push_i;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // The skid entry is never occupied while the output register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry holds a beat ahead of the output register");

  // A beat pushed while the output is stalled lands in the skid entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && main_valid_q && !pop |=> skid_valid_q)
    else $error("pushed beat lost during stall");

  // A stalled output with a waiting skid beat keeps both entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !pop |=> skid_valid_q && main_valid_q)
    else $error("buffered beat dropped");

endmodule

### hw/rtl/hash_db_record_parser_core.sv
// Top level of the hash-database record parser.
// Depends on hdbrp_pkg, hdbrp_parser and hdbrp_out_buf.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o   | data_byte_i
//   out     | output    | out_valid_o / out_stall_i | byte_value_o, byte_role_o,
//           |           |                           | record_done_o, record_base_o,
//           |           |                           | key_length_o, value_length_o
//   cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// Each input beat is decoded in the cycle it is accepted and its result is
// registered in the two-entry buffer; one byte per cycle is sustained while
// in_stall_o is low. The skid entry takes one more beat after the output
// stalls; in_stall_o rises only when both entries are held.
// Reset clears the parser to scanning at offset zero with 16-byte alignment
// and 4-byte links; writing start_offset restarts the scan at that offset.
module hash_db_record_parser_core import hdbrp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         byte_value_o,
  output logic [1:0]         byte_role_o,
  output logic               record_done_o,
  output logic [PosW-1:0]    record_base_o,
  output logic [LenW-1:0]    key_length_o,
  output logic [LenW-1:0]    value_length_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic [3:0] align_pow_r_q;
  logic       wide_links_q;
  logic       full;
  logic       accept;
  restart_t   restart;
  result_t    step_result;
  result_t    out_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_pow_r_q <= AlignPowReset;
      wide_links_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ALIGNMENT_POW) align_pow_r_q <= cfg_wdata_i[3:0];
      if (cfg_index_i == CFG_WIDE_LINKS) wide_links_q <= cfg_wdata_i[0];
    end
  end

  // A start-offset write reloads the position and restarts the scan.
  assign restart = '{load:   cfg_we_i && (cfg_index_i == CFG_START_OFFSET),
                     offset: cfg_wdata_i[PosW-1:0]};

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  hdbrp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .data_byte_i  (data_byte_i),
    .restart_i    (restart),
    .align_pow_i  (align_pow_r_q),
    .wide_links_i (wide_links_q),
    .result_o     (step_result)
  );

  hdbrp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (step_result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  // Result beat onto the output ports.
  assign byte_value_o   = out_data.byte_value;
  assign byte_role_o    = out_data.byte_role;
  assign record_done_o  = out_data.record_done;
  assign record_base_o  = out_data.record_base;
  assign key_length_o   = out_data.key_length;
  assign value_length_o = out_data.value_length;

endmodule

### tb/tb_hash_db_record_parser_core.sv
// Self-checking testbench for hash_db_record_parser_core.
// Depends on hdbrp_pkg and the parser RTL. It drives byte beats and checks every result beat
// against a byte-by-byte predictor of the record parser that lives in this file.
module tb_hash_db_record_parser_core import hdbrp_pkg::*; ();

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned ReportCap     = 100;
  localparam int unsigned PhaseBeats    = 70;
  localparam int unsigned NumPhases     = 12;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // Tracks the parser state per accepted byte and keeps the result beats still owed.
  class record_tracker;
    phase_e          cur_phase;
    logic [PosW-1:0] file_pos;
    logic [PosW-1:0] rec_base;
    logic [LenW-1:0] left_count;
    logic [LenW-1:0] vint_acc;
    logic [LenW-1:0] key_len;
    logic [LenW-1:0] val_len;
    int unsigned     vint_shift;
    logic [15:0]     pad_len;
    logic [3:0]      align_exp;
    logic            long_links;
    result_t         awaited_beats[$];
    int unsigned     faults;

    function new();
      cur_phase   = PH_SCAN;
      file_pos    = '0;
      rec_base    = '0;
      left_count  = '0;
      vint_acc    = '0;
      key_len     = '0;
      val_len     = '0;
      vint_shift  = 0;
      pad_len     = '0;
      align_exp   = AlignPowReset;
      long_links  = 1'b0;
      faults      = 0;
    endfunction

    // Move to the first body section that still has bytes; returns 1 when the record ends.
    function logic open_body(phase_e first_sec);
      if (first_sec == PH_KEY && key_len != '0) begin
        left_count = key_len;
        cur_phase  = PH_KEY;
        return 1'b0;
      end
      if (first_sec != PH_PADDING && val_len != '0) begin
        left_count = val_len;
        cur_phase  = PH_VAL;
        return 1'b0;
      end
      if (pad_len != '0) begin
        left_count = {16'd0, pad_len};
        cur_phase  = PH_PADDING;
        return 1'b0;
      end
      cur_phase = PH_SCAN;
      return 1'b1;
    endfunction

    // A start offset write restarts the scan; unknown indexes are dropped.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_START_OFFSET: begin
          file_pos    = data;
          cur_phase   = PH_SCAN;
          left_count  = '0;
          vint_acc    = '0;
          vint_shift  = 0;
        end
        CFG_ALIGNMENT_POW: align_exp = data[3:0];
        CFG_WIDE_LINKS: long_links = data[0];
        default: ;
      endcase
    endfunction

    // Advance the parser by one accepted byte and queue the beat it must produce.
    function void take_byte(logic [7:0] b);
      logic [PosW-1:0] nxt;
      logic [PosW-1:0] amask;
      logic [LenW-1:0] term;
      role_e           role;
      logic            done;
      result_t         beat;
      nxt   = file_pos + 1'b1;
      amask = (PosW'(1) << align_exp) - 1'b1;
      role  = ROLE_HDR;
      done  = 1'b0;
      case (cur_phase)
        PH_SCAN: begin
          rec_base = file_pos;
          if (b == MagicData) begin
            cur_phase  = PH_HDR;
            left_count = long_links ? HdrLenWide : HdrLenNarrow;
            key_len    = '0;
            val_len    = '0;
            pad_len    = '0;
          end else if (b == MagicFree) begin
            cur_phase  = PH_FREE;
            left_count = FreeLen;
          end else if ((nxt & amask) != '0) begin
            cur_phase = PH_ALIGN;
          end
        end
        PH_HDR: begin
          left_count--;
          if (left_count == '0) cur_phase = PH_PAD0;
        end
        PH_PAD0: begin
          pad_len   = {8'd0, b};
          cur_phase = PH_PAD1;
        end
        PH_PAD1: begin
          pad_len[15:8] = b;
          vint_acc      = '0;
          vint_shift    = 0;
          cur_phase     = PH_KEYVAR;
        end
        PH_KEYVAR, PH_VALVAR: begin
          // Continuation bytes carry the inverted low seven bits.
          if (b[7]) term = {25'd0, ~b[6:0]};
          else term = {24'd0, b};
          if (vint_shift < 32) vint_acc = vint_acc + (term << vint_shift);
          if (b[7]) begin
            vint_shift = (vint_shift + 7 > 35) ? 35 : vint_shift + 7;
          end else if (cur_phase == PH_KEYVAR) begin
            key_len    = vint_acc;
            vint_acc   = '0;
            vint_shift = 0;
            cur_phase  = PH_VALVAR;
          end else begin
            val_len    = vint_acc;
            vint_acc   = '0;
            vint_shift = 0;
            done       = open_body(PH_KEY);
          end
        end
        PH_KEY: begin
          role = ROLE_KEY;
          left_count--;
          if (left_count == '0) done = open_body(PH_VAL);
        end
        PH_VAL: begin
          role = ROLE_VALUE;
          left_count--;
          if (left_count == '0) done = open_body(PH_PADDING);
        end
        PH_PADDING: begin
          left_count--;
          if (left_count == '0) begin
            cur_phase = PH_SCAN;
            done      = 1'b1;
          end
        end
        PH_FREE: begin
          left_count--;
          if (left_count == '0) cur_phase = PH_SCAN;
        end
        PH_ALIGN: begin
          if ((nxt & amask) == '0) cur_phase = PH_SCAN;
        end
        default: cur_phase = PH_SCAN;
      endcase
      file_pos = nxt;

      beat.byte_value   = b;
      beat.byte_role    = role;
      beat.record_done  = done;
      beat.record_base  = rec_base;
      beat.key_length   = key_len;
      beat.value_length = val_len;
      awaited_beats.push_back(beat);
    endfunction

    function int unsigned pending();
      return awaited_beats.size();
    endfunction

    function void cmp_field(string name, logic [PosW-1:0] want, logic [PosW-1:0] got);
      if (got !== want) begin
        faults++;
        if (faults <= ReportCap) $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      end
    endfunction

    // Compare one result beat with the oldest owed beat.
    function void match_beat(logic [7:0] val, logic [1:0] role, logic done,
                             logic [PosW-1:0] off, logic [LenW-1:0] klen,
                             logic [LenW-1:0] vlen);
      result_t want;
      if (awaited_beats.size() == 0) begin
        faults++;
        $error("result beat with no expected beat waiting");
        return;
      end
      want = awaited_beats.pop_front();
      cmp_field("byte_value", want.byte_value, val);
      cmp_field("byte_role", want.byte_role, role);
      cmp_field("record_done", want.record_done, done);
      cmp_field("record_base", want.record_base, off);
      cmp_field("key_length", want.key_length, klen);
      cmp_field("value_length", want.value_length, vlen);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         byte_value;
  logic [1:0]         byte_role;
  logic               record_done;
  logic [PosW-1:0]    record_base;
  logic [LenW-1:0]    key_length;
  logic [LenW-1:0]    value_length;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  record_tracker walker;
  logic [7:0]    rec_bytes[$];
  int unsigned   bytes_sent = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  bit            hold_req = 1'b0;
  logic [3:0]    cur_pow = AlignPowReset;
  logic          cur_wide = 1'b0;
  int unsigned   quiet_cycles = 0;

  hash_db_record_parser_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (in_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .byte_value_o   (byte_value),
    .byte_role_o    (byte_role),
    .record_done_o  (record_done),
    .record_base_o  (record_base),
    .key_length_o   (key_length),
    .value_length_o (value_length),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Clock with a 12 unit period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random stall, plus one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Check every result beat taken at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      walker.match_beat(byte_value, byte_role, record_done, record_base, key_length,
                        value_length);
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CfgW-1:0] rand_cfg_word();
    return {16'($urandom), $urandom};
  endfunction

  // Offer one byte beat and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walker.take_byte(b);
    bytes_sent++;
  endtask

  // Stop offering and wait until every owed result beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (walker.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    walker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Change alignment and link width while a record is in flight.
  task automatic mid_record_writes();
    logic [CfgW-1:0] word;
    drain();
    word      = rand_cfg_word();
    word[3:0] = 4'($urandom_range(0, 6));
    write_reg(CFG_ALIGNMENT_POW, word);
    cur_pow   = word[3:0];
    word      = rand_cfg_word();
    write_reg(CFG_WIDE_LINKS, word);
    cur_wide  = word[0];
  endtask

  task automatic send_queue(input bit split);
    int unsigned i;
    for (i = 0; i < rec_bytes.size(); i++) begin
      if (split && i == 2) mid_record_writes();
      send_byte(rec_bytes[i]);
    end
  endtask

  // Size varint for a small size: a single byte, or a continuation form whose
  // later digits are zero or fall beyond 32 bits.
  function automatic void push_size(int unsigned n);
    int unsigned extra;
    int unsigned i;
    if ($urandom_range(0, 3) != 0) begin
      rec_bytes.push_back(8'(n));
      return;
    end
    extra = $urandom_range(0, 6);
    rec_bytes.push_back({1'b1, ~7'(n)});
    for (i = 1; i <= extra; i++) begin
      rec_bytes.push_back((7 * i >= 32) ? {1'b1, 7'($urandom)} : 8'hff);
    end
    rec_bytes.push_back((7 * (extra + 1) >= 32) ? {1'b0, 7'($urandom)} : 8'h00);
  endfunction

  function automatic void push_wild_varint();
    int unsigned n;
    n = $urandom_range(0, 5);
    repeat (n) rec_bytes.push_back({1'b1, 7'($urandom)});
    rec_bytes.push_back({1'b0, 7'($urandom)});
  endfunction

  // A well-formed data record with random content and small sizes.
  task automatic send_record(input bit split);
    int unsigned klen;
    int unsigned vlen;
    int unsigned plen;
    int unsigned hdr;
    rec_bytes.delete();
    klen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
    vlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
    if ($urandom_range(0, 29) == 0) plen = $urandom_range(256, 300);
    else plen = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    hdr = cur_wide ? HdrLenWide : HdrLenNarrow;
    rec_bytes.push_back(MagicData);
    repeat (hdr) rec_bytes.push_back(8'($urandom));
    rec_bytes.push_back(plen[7:0]);
    rec_bytes.push_back(plen[15:8]);
    push_size(klen);
    push_size(vlen);
    repeat (klen + vlen + plen) rec_bytes.push_back(8'($urandom));
    send_queue(split);
  endtask

  task automatic send_free();
    rec_bytes.delete();
    rec_bytes.push_back(MagicFree);
    repeat (FreeLen) rec_bytes.push_back(8'($urandom));
    send_queue(1'b0);
  endtask

  // One stray byte, then random filler until scanning resumes at a boundary.
  task automatic send_noise();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == MagicData || b == MagicFree) b = b ^ 8'h01;
    send_byte(b);
    while (walker.cur_phase == PH_ALIGN) send_byte(8'($urandom));
  endtask

  // A record cut short with random sizes; the next start offset write recovers.
  task automatic send_cut_record();
    int unsigned n;
    rec_bytes.delete();
    rec_bytes.push_back(MagicData);
    n = cur_wide ? HdrLenWide : HdrLenNarrow;
    repeat (n + 2) rec_bytes.push_back(8'($urandom));
    push_wild_varint();
    push_wild_varint();
    n = $urandom_range(0, 5);
    repeat (n) rec_bytes.push_back(8'($urandom));
    send_queue(1'b0);
  endtask

  task automatic start_phase(input logic [CfgW-1:0] base, input logic [3:0] pw,
                             input logic wl);
    logic [CfgW-1:0] word;
    drain();
    write_reg(CfgUnused, rand_cfg_word());
    word      = rand_cfg_word();
    word[3:0] = pw;
    write_reg(CFG_ALIGNMENT_POW, word);
    word      = rand_cfg_word();
    word[0]   = wl;
    write_reg(CFG_WIDE_LINKS, word);
    write_reg(CFG_START_OFFSET, base);
    cur_pow  = pw;
    cur_wide = wl;
  endtask

  // Mostly well-formed records and free blocks, with stray bytes where alignment is small.
  task automatic run_phase(input bit squeeze, input bit split_one);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + PhaseBeats;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15 && cur_pow <= 6) begin
        send_noise();
      end else if (pick < 30) begin
        send_free();
      end else begin
        send_record(split_one);
        split_one = 1'b0;
      end
      if (squeeze) begin
        hold_req = 1'b1;
        squeeze  = 1'b0;
      end
    end
    if ($urandom_range(0, 1) == 1) send_cut_record();
  endtask

  initial begin : stimulus
    int unsigned     ph_i;
    logic [CfgW-1:0] base;
    logic [3:0]      pw;
    logic            wl;
    walker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: an empty record, a stray byte with a skipped magic, a free block.
    send_idle_pct = 8;
    recv_idle_pct = 80;
    rec_bytes = '{MagicData, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'hff, MagicData, MagicFree, 8'h00, 8'hff,
                  8'h55, 8'haa};
    send_queue(1'b0);

    // Random phases, each with its own register settings; the idle pattern changes every four phases.
    for (ph_i = 0; ph_i < NumPhases; ph_i++) begin
      case (ph_i)
        0: begin
          base = '0;
          pw   = 4'd0;
          wl   = 1'b0;
        end
        1: begin
          base = 48'hffff_ffff_fff0;
          pw   = 4'd4;
          wl   = 1'b1;
        end
        2: begin
          base = rand_cfg_word();
          pw   = 4'd15;
          wl   = 1'b0;
        end
        3: begin
          base = '1;
          pw   = 4'd1;
          wl   = 1'b1;
        end
        default: begin
          base = rand_cfg_word();
          pw   = ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 6));
          wl   = 1'($urandom_range(0, 1));
        end
      endcase
      if (ph_i < 4) begin
        send_idle_pct = 8;
        recv_idle_pct = 80;
      end else if (ph_i < 8) begin
        send_idle_pct = 80;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      start_phase(base, pw, wl);
      run_phase(ph_i == 1, ph_i == 5);
    end

    drain();
    repeat (6) @(posedge clk);
    if (walker.faults == 0 && walker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/hdbrp_pkg.sv
hw/rtl/hdbrp_parser.sv
hw/rtl/hdbrp_out_buf.sv
hw/rtl/hash_db_record_parser_core.sv
tb/tb_hash_db_record_parser_core.sv
